FILE: hdl/mrp_pkg.sv
// Shared types, constants and the CRC-16 step for the meter poller.
`default_nettype none

package mrp_pkg;

  // Response frame store depth
  localparam int MAX_FRAME_BYTES = 9;
  localparam int FIDX_W          = $clog2(MAX_FRAME_BYTES);

  // Frame lengths for one-register and two-register reads
  localparam logic [3:0] FRAME_LEN_ONE = 4'd7;
  localparam logic [3:0] FRAME_LEN_TWO = 4'd9;

  // Protocol constants
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;

  // Input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // Result kind codes
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

  // Request byte positions
  localparam logic [2:0] REQ_ADDR    = 3'd0;
  localparam logic [2:0] REQ_FUNC    = 3'd1;
  localparam logic [2:0] REQ_REG_HI  = 3'd2;
  localparam logic [2:0] REQ_REG_LO  = 3'd3;
  localparam logic [2:0] REQ_CNT_HI  = 3'd4;
  localparam logic [2:0] REQ_CNT_LO  = 3'd5;
  localparam logic [2:0] REQ_CRC_LO  = 3'd6;
  localparam logic [2:0] REQ_CRC_HI  = 3'd7;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEV_ADDR  = 3'd0,
    CFG_VOLT_REG  = 3'd1,
    CFG_CURR_REG  = 3'd2,
    CFG_ENER_REG  = 3'd3,
    CFG_SHORT_TO  = 3'd4,
    CFG_LONG_TO   = 3'd5
  } cfg_idx_e;

  // Polling phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_VOLT = 4'b0010,
    PH_CURR = 4'b0100,
    PH_ENER = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } mrp_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        frame_ok;
    logic [15:0] voltage_tenths;
    logic [15:0] current_tenths;
    logic [31:0] power_hundredths;
    logic [31:0] energy_bits;
  } mrp_out_t;

  // Work handed from the protocol core to the result sequencer
  typedef struct packed {
    logic        meas;      // emit a measurement update
    logic        ok;        // frame matched address and CRC
    logic        fin;       // measurement is the final word
    logic        req;       // emit a read request
    logic [15:0] poll_reg;
    logic        two_regs;  // request two registers instead of one
  } mrp_job_t;

  // One byte of CRC-16, reflected polynomial
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/modbus_rtu_meter_poller.sv
// Top level of the Modbus RTU meter poller.
//
//   port group  dir  handshake        payload
//   in          in   in_valid/ready   mrp_in_t  (cmd, rx_byte)
//   out         out  out_valid/ready  mrp_out_t (request byte or measurement)
//   cfg         in   cfg_we           cfg_index (3b), cfg_wdata (16b)
//
// A word that yields no result leaves the input ready for the next word. A word
// that yields results is processed in the cycle it is taken; its results then
// leave one per cycle from the output register while the output is not stalled:
// a tick from idle gives 8 words, a completed response 9 (or 1 at the end of the
// cycle). The next input word is taken once the last result has entered the
// output register. Reset returns to idle with all readings zero. A stall on the
// output holds the sequencer in place.
`default_nettype none

module modbus_rtu_meter_poller import mrp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire mrp_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output mrp_out_t         out_data_o
);

  mrp_job_t    job;
  logic        busy, in_fire;
  logic [7:0]  dev_addr;
  logic [15:0] voltage, current;
  logic [31:0] energy;

  // Take a new word whenever the sequencer has no job left
  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && !busy;

  mrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_data_i   (in_data_i),
    .job_o       (job),
    .dev_addr_o  (dev_addr),
    .voltage_o   (voltage),
    .current_o   (current),
    .energy_o    (energy)
  );

  mrp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .dev_addr_i  (dev_addr),
    .voltage_i   (voltage),
    .current_i   (current),
    .energy_i    (energy),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hdl/mrp_core.sv
// Protocol core: configuration, phase, timeout, response capture and checking.
`default_nettype none

module mrp_core import mrp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_fire_i,
  input  wire mrp_in_t     in_data_i,
  output mrp_job_t         job_o,
  output logic [7:0]       dev_addr_o,
  output logic [15:0]      voltage_o,
  output logic [15:0]      current_o,
  output logic [31:0]      energy_o
);

  logic [7:0]  dev_addr_q;
  logic [15:0] volt_reg_q, curr_reg_q, ener_reg_q, short_to_q, long_to_q;

  phase_e      phase_q, phase_d;
  logic [15:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [3:0]  rx_count_q, rx_count_d, cnt_next, len;
  logic [15:0] rx_crc_q, rx_crc_d, pkt_crc;
  logic [15:0] volt_q, volt_d, curr_q, curr_d;
  logic [31:0] ener_q, ener_d;
  logic [7:0]  frame_q [MAX_FRAME_BYTES];
  logic        frame_we, addr_ok;
  logic [7:0]  crc_lo_byte, crc_hi_byte;
  mrp_job_t    job;

  // Read a stored frame byte at a fixed position; beyond the store reads zero
  function automatic logic [7:0] frame_rd(input int idx, input logic [7:0] mem [MAX_FRAME_BYTES]);
    logic [7:0] v;
    v = 8'h00;
    if (idx < MAX_FRAME_BYTES) begin
      v = mem[FIDX_W'(idx)];
    end
    return v;
  endfunction

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 8'd1;
      volt_reg_q <= 16'd0;
      curr_reg_q <= 16'd0;
      ener_reg_q <= 16'd0;
      short_to_q <= 16'd50;
      long_to_q  <= 16'd200;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEV_ADDR: dev_addr_q <= cfg_wdata_i[7:0];
        CFG_VOLT_REG: volt_reg_q <= cfg_wdata_i;
        CFG_CURR_REG: curr_reg_q <= cfg_wdata_i;
        CFG_ENER_REG: ener_reg_q <= cfg_wdata_i;
        CFG_SHORT_TO: short_to_q <= cfg_wdata_i;
        CFG_LONG_TO:  long_to_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame bookkeeping shared by the next-state logic
  assign len         = (phase_q == PH_ENER) ? FRAME_LEN_TWO : FRAME_LEN_ONE;
  assign cnt_next    = rx_count_q + 4'd1;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  // Received CRC: low byte is stored, high byte is the one arriving now
  always_comb begin
    if (phase_q == PH_ENER) begin
      crc_lo_byte = frame_rd(int'(FRAME_LEN_TWO) - 2, frame_q);
      crc_hi_byte = (int'(FRAME_LEN_TWO) - 1 < MAX_FRAME_BYTES) ? in_data_i.rx_byte : 8'h00;
    end else begin
      crc_lo_byte = frame_rd(int'(FRAME_LEN_ONE) - 2, frame_q);
      crc_hi_byte = (int'(FRAME_LEN_ONE) - 1 < MAX_FRAME_BYTES) ? in_data_i.rx_byte : 8'h00;
    end
  end
  assign pkt_crc = {crc_hi_byte, crc_lo_byte};
  assign addr_ok = (frame_rd(0, frame_q) == dev_addr_q);

  // Advance the poll cycle on each accepted word
  always_comb begin
    phase_d    = phase_q;
    elapsed_d  = elapsed_q;
    rx_count_d = rx_count_q;
    rx_crc_d   = rx_crc_q;
    volt_d     = volt_q;
    curr_d     = curr_q;
    ener_d     = ener_q;
    frame_we   = 1'b0;
    job        = '0;
    if (in_fire_i) begin
      if (in_data_i.cmd == CMD_TICK) begin
        if (phase_q == PH_IDLE) begin
          phase_d      = PH_VOLT;
          job.req      = 1'b1;
          job.poll_reg = volt_reg_q;
          elapsed_d    = '0;
          rx_count_d   = '0;
          rx_crc_d     = CRC_INIT;
        end else begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > ((phase_q == PH_VOLT) ? short_to_q : long_to_q)) begin
            phase_d = PH_IDLE;
          end
        end
      end else if (phase_q != PH_IDLE) begin
        frame_we   = (int'(rx_count_q) < MAX_FRAME_BYTES);
        if (rx_count_q < len - 4'd2) begin
          rx_crc_d = crc_byte(rx_crc_q, in_data_i.rx_byte);
        end
        rx_count_d = cnt_next;
        if (cnt_next >= len) begin
          job.meas = 1'b1;
          job.ok   = (pkt_crc == rx_crc_q) && addr_ok;
          if (job.ok) begin
            case (phase_q)
              PH_VOLT: volt_d = {frame_rd(3, frame_q), frame_rd(4, frame_q)};
              PH_CURR: curr_d = {frame_rd(3, frame_q), frame_rd(4, frame_q)};
              default: ener_d = {frame_rd(3, frame_q), frame_rd(4, frame_q),
                                 frame_rd(5, frame_q), frame_rd(6, frame_q)};
            endcase
          end
          elapsed_d  = '0;
          rx_count_d = '0;
          rx_crc_d   = CRC_INIT;
          case (phase_q)
            PH_VOLT: begin
              phase_d      = PH_CURR;
              job.req      = 1'b1;
              job.poll_reg = curr_reg_q;
            end
            PH_CURR: begin
              phase_d      = PH_ENER;
              job.req      = 1'b1;
              job.poll_reg = ener_reg_q;
              job.two_regs = 1'b1;
            end
            default: begin
              phase_d   = PH_IDLE;
              elapsed_d = elapsed_q;
              job.fin   = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Hold control state and stored readings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elapsed_q  <= '0;
      rx_count_q <= '0;
      rx_crc_q   <= CRC_INIT;
      volt_q     <= '0;
      curr_q     <= '0;
      ener_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      rx_count_q <= rx_count_d;
      rx_crc_q   <= rx_crc_d;
      volt_q     <= volt_d;
      curr_q     <= curr_d;
      ener_q     <= ener_d;
    end
  end

  // Capture response bytes
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_q[rx_count_q[FIDX_W-1:0]] <= in_data_i.rx_byte;
    end
  end

  assign job_o      = job;
  assign dev_addr_o = dev_addr_q;
  assign voltage_o  = volt_q;
  assign current_o  = curr_q;
  assign energy_o   = ener_q;

endmodule

`default_nettype wire

FILE: hdl/mrp_emit.sv
// Result sequencer: measurement word, request bytes with running CRC, output register.
`default_nettype none

module mrp_emit import mrp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mrp_job_t    job_i,
  input  wire logic [7:0]  dev_addr_i,
  input  wire logic [15:0] voltage_i,
  input  wire logic [15:0] current_i,
  input  wire logic [31:0] energy_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output mrp_out_t         out_data_o
);

  logic        pend_meas_q, pend_req_q, ok_q, fin_q, two_q;
  logic [15:0] reg_q, crc_q;
  logic [2:0]  idx_q;
  logic        out_valid_q, load;
  mrp_out_t    out_q, meas_word, req_word;
  logic [7:0]  req_byte;

  assign load   = !out_valid_q || out_ready_i;
  assign busy_o = pend_meas_q || pend_req_q;

  // Pick the current request byte
  always_comb begin
    case (idx_q)
      REQ_ADDR:   req_byte = dev_addr_i;
      REQ_FUNC:   req_byte = FUNC_READ_HOLD;
      REQ_REG_HI: req_byte = reg_q[15:8];
      REQ_REG_LO: req_byte = reg_q[7:0];
      REQ_CNT_HI: req_byte = 8'h00;
      REQ_CNT_LO: req_byte = two_q ? 8'd2 : 8'd1;
      REQ_CRC_LO: req_byte = crc_q[7:0];
      REQ_CRC_HI: req_byte = crc_q[15:8];
      default:    req_byte = 8'h00;
    endcase
  end

  // Build both word shapes
  always_comb begin
    meas_word                  = '0;
    meas_word.kind             = KIND_MEAS;
    meas_word.last             = fin_q;
    meas_word.frame_ok         = ok_q;
    meas_word.voltage_tenths   = voltage_i;
    meas_word.current_tenths   = current_i;
    meas_word.power_hundredths = 32'(voltage_i) * 32'(current_i);
    meas_word.energy_bits      = energy_i;
    req_word                   = '0;
    req_word.kind              = KIND_REQ;
    req_word.tx_byte           = req_byte;
    req_word.last              = (idx_q == REQ_CRC_HI);
  end

  // Sequence the words of one job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_meas_q <= 1'b0;
      pend_req_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= pend_meas_q || pend_req_q;
        if (pend_meas_q) begin
          pend_meas_q <= 1'b0;
        end else if (pend_req_q) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == REQ_CRC_HI) begin
            pend_req_q <= 1'b0;
          end
        end
      end
      if (job_i.meas || job_i.req) begin
        pend_meas_q <= job_i.meas;
        pend_req_q  <= job_i.req;
        idx_q       <= '0;
      end
    end
  end

  // Hold job details, running request CRC and the output word
  always_ff @(posedge clk_i) begin
    if (job_i.meas || job_i.req) begin
      ok_q  <= job_i.ok;
      fin_q <= job_i.fin;
      reg_q <= job_i.poll_reg;
      two_q <= job_i.two_regs;
      crc_q <= CRC_INIT;
    end else if (load && !pend_meas_q && pend_req_q && idx_q < REQ_CRC_LO) begin
      crc_q <= crc_byte(crc_q, req_byte);
    end
    if (load) begin
      out_q <= pend_meas_q ? meas_word : req_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: tb/meter_poll_checker.sv
// Result checker for the meter poller: predicts every result word and compares it.
`timescale 1ns / 100ps

module meter_poll_checker import mrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  mrp_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  mrp_out_t    out_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Register copies
  logic [7:0]  dev_addr_q;
  logic [15:0] volt_reg_q;
  logic [15:0] curr_reg_q;
  logic [15:0] ener_reg_q;
  logic [15:0] short_to_q;
  logic [15:0] long_to_q;

  // Poller state
  phase_e      phase_q;
  logic [15:0] ticks_q;
  logic [3:0]  rx_cnt_q;
  logic [7:0]  frame_q [MAX_FRAME_BYTES];
  logic [15:0] crc_q;
  logic [15:0] volt_q;
  logic [15:0] curr_q;
  logic [31:0] ener_q;

  mrp_out_t expected_words[$];
  int       failures = 0;

  // One byte of CRC-16/MODBUS, shifted out LSB first
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                  input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      if (c[0]) c = {1'b0, c[15:1]} ^ CRC_POLY;
      else      c = {1'b0, c[15:1]};
    end
    return c;
  endfunction

  // Queue the eight bytes of a read request and arm reception
  task automatic push_request(input logic [15:0] poll_reg, input logic [15:0] reg_count);
    logic [7:0]  req [8];
    logic [15:0] crc;
    mrp_out_t    w;
    req[REQ_ADDR]   = dev_addr_q;
    req[REQ_FUNC]   = FUNC_READ_HOLD;
    req[REQ_REG_HI] = poll_reg[15:8];
    req[REQ_REG_LO] = poll_reg[7:0];
    req[REQ_CNT_HI] = reg_count[15:8];
    req[REQ_CNT_LO] = reg_count[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = modbus_crc_step(crc, req[3'(i)]);
    req[REQ_CRC_LO] = crc[7:0];
    req[REQ_CRC_HI] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      w         = '0;
      w.kind    = KIND_REQ;
      w.tx_byte = req[3'(i)];
      w.last    = (3'(i) == REQ_CRC_HI);
      expected_words.push_back(w);
    end
    ticks_q  = '0;
    rx_cnt_q = '0;
    crc_q    = CRC_INIT;
  endtask

  // Advance the poller by one accepted input word
  task automatic predict_word(input mrp_in_t w);
    logic [3:0]  len;
    logic [15:0] frame_crc;
    logic        ok;
    mrp_out_t    m;
    if (w.cmd == CMD_TICK) begin
      if (phase_q == PH_IDLE) begin
        phase_q = PH_VOLT;
        push_request(volt_reg_q, 16'd1);
      end else begin
        if (ticks_q != 16'hFFFF) ticks_q = ticks_q + 16'd1;
        if (ticks_q > ((phase_q == PH_VOLT) ? short_to_q : long_to_q)) phase_q = PH_IDLE;
      end
    end else if (phase_q != PH_IDLE) begin
      len = (phase_q == PH_ENER) ? FRAME_LEN_TWO : FRAME_LEN_ONE;
      if (rx_cnt_q < MAX_FRAME_BYTES) frame_q[rx_cnt_q] = w.rx_byte;
      if (rx_cnt_q < len - 4'd2) crc_q = modbus_crc_step(crc_q, w.rx_byte);
      rx_cnt_q = rx_cnt_q + 4'd1;
      if (rx_cnt_q >= len) begin
        frame_crc = {frame_q[len - 4'd1], frame_q[len - 4'd2]};
        ok        = (frame_crc == crc_q) && (frame_q[0] == dev_addr_q);
        // Keep the stored value on a bad frame
        if (ok) begin
          case (phase_q)
            PH_VOLT: volt_q = {frame_q[3], frame_q[4]};
            PH_CURR: curr_q = {frame_q[3], frame_q[4]};
            default: ener_q = {frame_q[3], frame_q[4], frame_q[5], frame_q[6]};
          endcase
        end
        m                  = '0;
        m.kind             = KIND_MEAS;
        m.last             = (phase_q == PH_ENER);
        m.frame_ok         = ok;
        m.voltage_tenths   = volt_q;
        m.current_tenths   = curr_q;
        m.power_hundredths = 32'(volt_q) * 32'(curr_q);
        m.energy_bits      = ener_q;
        expected_words.push_back(m);
        case (phase_q)
          PH_VOLT: begin
            phase_q = PH_CURR;
            push_request(curr_reg_q, 16'd1);
          end
          PH_CURR: begin
            phase_q = PH_ENER;
            push_request(ener_reg_q, 16'd2);
          end
          default: begin
            phase_q  = PH_IDLE;
            rx_cnt_q = '0;
            crc_q    = CRC_INIT;
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_word(input mrp_out_t want, input mrp_out_t got);
    check_field("kind", 32'(want.kind), 32'(got.kind));
    check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
    check_field("last", 32'(want.last), 32'(got.last));
    check_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
    check_field("voltage_tenths", 32'(want.voltage_tenths), 32'(got.voltage_tenths));
    check_field("current_tenths", 32'(want.current_tenths), 32'(got.current_tenths));
    check_field("power_hundredths", want.power_hundredths, got.power_hundredths);
    check_field("energy_bits", want.energy_bits, got.energy_bits);
  endtask

  // Track register writes, retire result words, predict input words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q = 8'd1;
      volt_reg_q = '0;
      curr_reg_q = '0;
      ener_reg_q = '0;
      short_to_q = 16'd50;
      long_to_q  = 16'd200;
      phase_q    = PH_IDLE;
      ticks_q    = '0;
      rx_cnt_q   = '0;
      crc_q      = CRC_INIT;
      volt_q     = '0;
      curr_q     = '0;
      ener_q     = '0;
      frame_q    = '{default: 8'h00};
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEV_ADDR: dev_addr_q = cfg_wdata_i[7:0];
          CFG_VOLT_REG: volt_reg_q = cfg_wdata_i;
          CFG_CURR_REG: curr_reg_q = cfg_wdata_i;
          CFG_ENER_REG: ener_reg_q = cfg_wdata_i;
          CFG_SHORT_TO: short_to_q = cfg_wdata_i;
          CFG_LONG_TO:  long_to_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          failures++;
          $display("%0t: result word %h arrived with nothing expected", $time, out_data_i);
        end else begin
          compare_word(expected_words.pop_front(), out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_word(in_data_i);
    end
    fail_count_o <= failures;
    pending_o    <= expected_words.size();
  end

endmodule

FILE: tb/modbus_rtu_meter_poller_test.sv
// Top of the meter poller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module modbus_rtu_meter_poller_test;
  import mrp_pkg::*;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WIDE_TICKS     = 5;

  // Indexes past the end of the register list
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mrp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mrp_out_t    out_data;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          results_taken = 0;
  int          cfg_writes = 0;
  bit          gaps_on = 1'b1;
  bit          hold_output = 1'b0;
  logic [7:0]  cur_dev = 8'd1;
  logic [15:0] cur_long = 16'd200;

  modbus_rtu_meter_poller i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  meter_poll_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modbus_rtu_meter_poller_test: errors");
      $finish;
    end
  end

  // Drain result words with random stalls and one long hold-off
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_output && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      stall = gaps_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // Offer one input word after a random gap and hold it until taken
  task automatic send_word(input logic cmd, input logic [7:0] data);
    int      gap;
    mrp_in_t w;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.cmd     = cmd;
    w.rx_byte = data;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_writes++;
  endtask

  // Write every register, plus the two unused indexes, which must be ignored
  task automatic apply_setting(input logic [7:0] dev, input logic [15:0] volt_reg,
                               input logic [15:0] curr_reg, input logic [15:0] ener_reg,
                               input logic [15:0] short_to, input logic [15:0] long_to);
    write_reg(CFG_DEV_ADDR, {8'($urandom), dev});
    write_reg(CFG_VOLT_REG, volt_reg);
    write_reg(CFG_CURR_REG, curr_reg);
    write_reg(CFG_ENER_REG, ener_reg);
    write_reg(CFG_SHORT_TO, short_to);
    write_reg(CFG_LONG_TO, long_to);
    write_reg(CFG_SPARE_A, 16'($urandom));
    write_reg(CFG_SPARE_B, 16'($urandom));
    cfg_we   <= 1'b0;
    cur_dev  = dev;
    cur_long = long_to;
  endtask

  // Drop valid, wait for every expected word, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send one slave response; noise_pct sets the chance of a tick before each byte
  task automatic send_response(input int n_data, input bit addr_ok, input bit crc_ok,
                               input logic [31:0] value, input int noise_pct);
    logic [7:0]  frame [9];
    logic [15:0] crc;
    int          len;
    len      = n_data + 5;
    frame[0] = addr_ok ? cur_dev : cur_dev ^ 8'($urandom_range(1, 255));
    frame[1] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_READ_HOLD;
    frame[2] = 8'(n_data);
    for (int i = 0; i < n_data; i++) begin
      frame[4'(3 + i)] = value[5'(8 * (n_data - 1 - i)) +: 8];
    end
    crc = CRC_INIT;
    for (int i = 0; i < len - 2; i++) crc = crc_byte(crc, frame[4'(i)]);
    if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 65535));
    frame[4'(len - 2)] = crc[7:0];
    frame[4'(len - 1)] = crc[15:8];
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(CMD_TICK, 8'($urandom));
      send_word(CMD_BYTE, frame[4'(i)]);
    end
  endtask

  // One polling round: tick, then voltage, current and energy responses
  task automatic poll_cycle(input bit allow_broken, input int noise_pct);
    bit broke;
    broke = 1'b0;
    send_word(CMD_TICK, 8'($urandom));
    for (int k = 0; k < 3; k++) begin
      if (allow_broken && $urandom_range(0, 9) == 0) begin
        broke = 1'b1;
        repeat ($urandom_range(1, 9)) send_word(CMD_BYTE, 8'($urandom));
      end else begin
        send_response((k == 2) ? 4 : 2, $urandom_range(0, 9) != 0,
                      $urandom_range(0, 7) != 0, $urandom, noise_pct);
      end
    end
    // Run the phase into its timeout so the next round starts aligned
    if (broke) repeat (cur_long + 2) send_word(CMD_TICK, 8'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: stray byte, then one full round with a corrupt current frame
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_TICK, 8'h00);
    send_response(2, 1'b1, 1'b1, 32'h0000_FFFF, 0);
    send_response(2, 1'b1, 1'b0, 32'h0000_1234, 0);
    send_response(4, 1'b1, 1'b1, 32'hFFFF_FFFF, 0);
    settle();

    // Tightest timeouts: time out in voltage and in current phase, then a noisy round
    apply_setting(8'hFF, 16'hFFFF, 16'h8000, 16'h0001, 16'd0, 16'd1);
    send_word(CMD_TICK, 8'($urandom));
    send_word(CMD_TICK, 8'($urandom));
    send_word(CMD_TICK, 8'($urandom));
    send_response(2, 1'b1, 1'b1, 32'h0000_0000, 0);
    send_word(CMD_TICK, 8'($urandom));
    send_word(CMD_TICK, 8'($urandom));
    poll_cycle(1'b1, 5);
    settle();

    // Widest timeouts: a few ticks while waiting, then finish the round
    gaps_on = 1'b0;
    apply_setting(8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(CMD_TICK, 8'($urandom));
    repeat (WIDE_TICKS) send_word(CMD_TICK, 8'($urandom));
    send_response(2, 1'b1, 1'b1, $urandom, 0);
    send_response(2, 1'b1, 1'b1, $urandom, 0);
    send_response(4, 1'b1, 1'b1, $urandom, 0);
    settle();

    // Random registers, short timeouts, noise and broken frames
    gaps_on = 1'b1;
    apply_setting(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'd3, 16'd8);
    poll_cycle(1'b1, 10);
    settle();

    // Usual timeouts; hold the output long enough to stall the input
    apply_setting(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'd50, 16'd200);
    hold_output = 1'b1;
    for (int c = 0; c < 2; c++) begin
      gaps_on = (c == 0);
      poll_cycle(1'b0, 3);
    end
    settle();

    $display("covered %0d input words, %0d result words, %0d register writes",
             words_sent, results_taken, cfg_writes);
    $display("timeouts, wide timeouts, corrupt and broken frames, output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("modbus_rtu_meter_poller_test: clean");
    end else begin
      $display("modbus_rtu_meter_poller_test: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mrp_pkg.sv
hdl/mrp_core.sv
hdl/mrp_emit.sv
hdl/modbus_rtu_meter_poller.sv
tb/meter_poll_checker.sv
tb/modbus_rtu_meter_poller_test.sv
